### design/rbsi_pkg.sv
package rbsi_pkg;

   localparam int CoordW    = 32;
   localparam int NumAxes   = 3;
   localparam int NumLanes  = 2 * NumAxes;
   localparam int FracW     = 16;
   localparam int RemW      = 32;
   localparam int DivW      = RemW + FracW;
   localparam int StepsPerStage = 4;
   localparam int DivStages = DivW / StepsPerStage;
   localparam int TW        = DivW + 2;
   localparam logic signed [TW-1:0] TBig = TW'(1) << DivW;
   localparam int ReqW      = 12 * CoordW;
   localparam int RspW      = 40;

   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [DivW-1:0] nq;
      logic [RemW-1:0] den;
      logic            neg;
      logic            dz;
      logic            in_slab;
      logic            below;
   } lane_type;

   // restoring division, StepsPerStage quotient bits
   function automatic lane_type div_steps(lane_type l);
      lane_type          r;
      logic [RemW:0]     trial;
      r = l;
      for (int i = 0; i < StepsPerStage; i++) begin
         trial = {r.rem, r.nq[DivW-1]};
         if (trial >= {1'b0, r.den}) begin
            trial = trial - {1'b0, r.den};
            r.nq  = {r.nq[DivW-2:0], 1'b1};
         end else begin
            r.nq  = {r.nq[DivW-2:0], 1'b0};
         end
         r.rem = trial[RemW-1:0];
      end
      return r;
   endfunction

endpackage

### design/ray_box_slab_intersect.sv
// Ray versus axis-aligned box slab test in signed Q16.16. One item (ray plus box)
// is accepted per clock while the rsp channel is not stalled; the six parallel
// pipelined dividers retire four quotient bits per stage over 48 bits. A stalled
// rsp channel holds the whole pipeline. hit is 1 when no zero-direction origin lies
// outside its slab, the largest entry t is positive and no exit t is below it;
// entry_t is that entry parameter, saturated to 32 bits.
module ray_box_slab_intersect
   import rbsi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // origin_x/y/z, dir_x/y/z, box_min_x/y/z, box_max_x/y/z, 32 bits each
   input  logic [ReqW-1:0] req_tdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   // hit [0], entry_t [32:1], zero pad [39:33]
   output logic [RspW-1:0] rsp_tdata
);

   localparam int VldW = DivStages + 5;

   logic            ce;
   logic [VldW-1:0] vld_ff;
   logic [VldW-1:0] vld_in;

   lane_type dv_ff [0:DivStages][0:NumLanes-1];
   lane_type dv_in [0:DivStages][0:NumLanes-1];

   logic signed [TW-1:0] t_ff     [0:NumLanes-1];
   logic signed [TW-1:0] t_in     [0:NumLanes-1];
   logic [NumAxes-1:0]   dz_ff, in_slab_ff, below_ff;

   logic signed [TW-1:0] ent_ff [0:NumAxes-1];
   logic signed [TW-1:0] lv_ff  [0:NumAxes-1];
   logic signed [TW-1:0] ent_in [0:NumAxes-1];
   logic signed [TW-1:0] lv_in  [0:NumAxes-1];
   logic [NumAxes-1:0]   miss_ff, miss_in;

   logic signed [TW-1:0] enter_ff, leave_ff, enter_in, leave_in;
   logic                 miss_all_ff, miss_all_in;

   logic                 hit_ff, hit_in;
   logic signed [CoordW-1:0] sat_ff, sat_in;

   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = vld_ff[VldW-1];
   assign rsp_tdata  = {{(RspW-CoordW-1){1'b0}}, sat_ff, hit_ff};

   assign vld_in = {vld_ff[VldW-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= vld_in;
      end
   end

   // operand prep: |b - o| << 16 over |d|, sign of quotient, zero-direction and in-slab/below-slab flags
   always_comb begin
      logic signed [CoordW:0]   o, b, d, diff, mag, dm;
      for (int l = 0; l < NumLanes; l++) begin
         o    = {req_tdata[(l/2)*CoordW + CoordW-1], req_tdata[(l/2)*CoordW +: CoordW]};
         d    = {req_tdata[(3 + l/2)*CoordW + CoordW-1],
                 req_tdata[(3 + l/2)*CoordW +: CoordW]};
         b    = {req_tdata[(6 + 3*(l%2) + l/2)*CoordW + CoordW-1],
                 req_tdata[(6 + 3*(l%2) + l/2)*CoordW +: CoordW]};
         diff = b - o;
         mag  = diff[CoordW] ? -diff : diff;
         dm   = d[CoordW] ? -d : d;
         dv_in[0][l].rem = '0;
         dv_in[0][l].nq  = {mag[RemW-1:0], {FracW{1'b0}}};
         dv_in[0][l].den = dm[RemW-1:0];
         dv_in[0][l].neg = diff[CoordW] ^ d[CoordW];
         dv_in[0][l].dz  = (d == '0);
         dv_in[0][l].in_slab = 1'b0;
         dv_in[0][l].below   = 1'b0;
      end
      for (int a = 0; a < NumAxes; a++) begin
         o = {req_tdata[a*CoordW + CoordW-1], req_tdata[a*CoordW +: CoordW]};
         b = {req_tdata[(6 + a)*CoordW + CoordW-1], req_tdata[(6 + a)*CoordW +: CoordW]};
         d = {req_tdata[(9 + a)*CoordW + CoordW-1], req_tdata[(9 + a)*CoordW +: CoordW]};
         dv_in[0][2*a].in_slab = (o >= b) && (o <= d);
         dv_in[0][2*a].below   = (o < b);
      end
   end

   genvar s;
   generate
      for (s = 1; s <= DivStages; s++) begin : g_div
         always_comb begin
            for (int l = 0; l < NumLanes; l++) begin
               dv_in[s][l] = div_steps(dv_ff[s-1][l]);
            end
         end
      end
      for (s = 0; s <= DivStages; s++) begin : g_dreg
         always_ff @(posedge clock) begin
            if (ce) begin
               for (int l = 0; l < NumLanes; l++) begin
                  dv_ff[s][l] <= dv_in[s][l];
               end
            end
         end
      end
   endgenerate

   // signed slab parameters
   always_comb begin
      logic signed [TW-1:0] q;
      for (int l = 0; l < NumLanes; l++) begin
         q       = {2'b00, dv_ff[DivStages][l].nq};
         t_in[l] = dv_ff[DivStages][l].neg ? -q : q;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int l = 0; l < NumLanes; l++) begin
            t_ff[l] <= t_in[l];
         end
         for (int a = 0; a < NumAxes; a++) begin
            dz_ff[a]      <= dv_ff[DivStages][2*a].dz;
            in_slab_ff[a] <= dv_ff[DivStages][2*a].in_slab;
            below_ff[a]   <= dv_ff[DivStages][2*a].below;
         end
      end
   end

   // per-axis entry and exit
   always_comb begin
      logic signed [TW-1:0] t1, t2;
      for (int a = 0; a < NumAxes; a++) begin
         t1 = t_ff[2*a];
         t2 = t_ff[2*a+1];
         if (dz_ff[a]) begin
            ent_in[a]  = (!in_slab_ff[a] && below_ff[a]) ? TBig : -TBig;
            lv_in[a]   = TBig;
            miss_in[a] = !in_slab_ff[a];
         end else begin
            ent_in[a]  = (t1 < t2) ? t1 : t2;
            lv_in[a]   = (t1 < t2) ? t2 : t1;
            miss_in[a] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int a = 0; a < NumAxes; a++) begin
            ent_ff[a] <= ent_in[a];
            lv_ff[a]  <= lv_in[a];
         end
         miss_ff <= miss_in;
      end
   end

   // combine axes
   always_comb begin
      enter_in = ent_ff[0];
      leave_in = lv_ff[0];
      for (int a = 1; a < NumAxes; a++) begin
         if (ent_ff[a] > enter_in) enter_in = ent_ff[a];
         if (lv_ff[a] < leave_in)  leave_in = lv_ff[a];
      end
      miss_all_in = |miss_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         enter_ff    <= enter_in;
         leave_ff    <= leave_in;
         miss_all_ff <= miss_all_in;
      end
   end

   // hit decision and saturation
   always_comb begin
      hit_in = !miss_all_ff && (leave_ff >= enter_ff) && (enter_ff > 0);
      if (enter_ff > TW'(32'sh7FFF_FFFF)) begin
         sat_in = 32'sh7FFF_FFFF;
      end else if (enter_ff < -TW'(64'sh8000_0000)) begin
         sat_in = 32'sh8000_0000;
      end else begin
         sat_in = enter_ff[CoordW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         hit_ff <= hit_in;
         sat_ff <= sat_in;
      end
   end

endmodule

### dv/tb_ray_box_slab_intersect.sv
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect
   import rbsi_pkg::*;
();

   typedef struct packed {
      logic        hit;
      logic [31:0] entry_t;
   } slab_result_type;

   localparam longint TInf = 64'sd1 <<< 62;
   localparam int WatchdogLimit = 20000;
   localparam int NumRandom = 400;

   logic            clock;
   logic            reset;
   logic            req_tvalid;
   logic            req_tready;
   logic [ReqW-1:0] req_tdata;
   logic            rsp_tvalid;
   logic            rsp_tready;
   logic [RspW-1:0] rsp_tdata;

   logic [ReqW-1:0] ray_queue[$];
   slab_result_type expected_hits[$];
   int              mismatches;
   int              idle_count;
   int              send_gap;
   int              recv_gap;
   int              hold_off;
   bit              hold_req;
   bit              burst_on;
   bit              pause_req;
   bit              stimulus_done;
   bit              req_taken;

   ray_box_slab_intersect uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic slab_result_type predict_slab_hit(logic [ReqW-1:0] ray);
      longint o, d, lo, hi, t1, t2, tn, tf, enter, leave, sat;
      bit miss;
      slab_result_type r;
      enter = -TInf;
      leave = TInf;
      miss = 0;
      for (int a = 0; a < 3; a++) begin
         o  = longint'($signed(ray[32*a +: 32]));
         d  = longint'($signed(ray[32*(3+a) +: 32]));
         lo = longint'($signed(ray[32*(6+a) +: 32]));
         hi = longint'($signed(ray[32*(9+a) +: 32]));
         if (d == 0) begin
            if (!(o >= lo && o <= hi)) begin
               miss = 1;
               if (o < lo) enter = TInf;
            end
         end else begin
            t1 = ((lo - o) * 65536) / d;
            t2 = ((hi - o) * 65536) / d;
            tn = (t1 < t2) ? t1 : t2;
            tf = (t1 < t2) ? t2 : t1;
            if (tn > enter) enter = tn;
            if (tf < leave) leave = tf;
         end
      end
      r.hit = !miss && leave >= enter && enter > 0;
      sat = enter;
      if (sat > 64'sd2147483647) sat = 64'sd2147483647;
      if (sat < -64'sd2147483648) sat = -64'sd2147483648;
      r.entry_t = sat[31:0];
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return 32'h8000_0000 + $urandom_range(0, 3);
         3: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         default: return 32'($signed($urandom_range(0, 400)) - 200) <<< 14;
      endcase
   endfunction

   function automatic logic [ReqW-1:0] make_ray(bit aimed);
      logic [31:0] f[12];
      logic [31:0] c, hw;
      for (int i = 0; i < 12; i++) f[i] = rand_coord();
      if (aimed) begin
         for (int a = 0; a < 3; a++) begin
            c  = 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            hw = $urandom_range(1, 5 << 16);
            f[6+a] = c - hw;
            f[9+a] = c + hw;
            f[a]   = 32'($signed($urandom_range(0, 80 << 16)) - (40 << 16));
            f[3+a] = (c - f[a]) >>> $urandom_range(0, 4);
            if ($urandom_range(0, 7) == 0) f[3+a] = '0;
            if ($urandom_range(0, 9) == 0) f[3+a] = f[3+a] + $urandom_range(0, 65535);
         end
      end
      return {f[11], f[10], f[9], f[8], f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
   endfunction

   function automatic logic [ReqW-1:0] pack_ray(logic [31:0] o[3], logic [31:0] d[3],
                                                logic [31:0] mn[3], logic [31:0] mx[3]);
      return {mx[2], mx[1], mx[0], mn[2], mn[1], mn[0], d[2], d[1], d[0], o[2], o[1], o[0]};
   endfunction

   initial begin
      logic [31:0] o[3], d[3], mn[3], mx[3];
      reset = 1'b1;
      stimulus_done = 0;
      pause_req = 0;
      hold_off = 0;
      mn = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
      mx = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
      // axis-aligned hits and misses, zero directions in and out of slab
      o = '{32'hFFFB_0000, 0, 0};       d = '{32'h0001_0000, 0, 0};
      ray_queue.push_back(pack_ray(o, d, mn, mx));
      o = '{32'hFFFB_0000, 32'h0001_0000, 0};
      ray_queue.push_back(pack_ray(o, d, mn, mx));
      o = '{32'hFFFB_0000, 32'h0002_0000, 0};
      ray_queue.push_back(pack_ray(o, d, mn, mx));
      o = '{32'hFFFB_0000, 32'hFFFD_0000, 0};
      ray_queue.push_back(pack_ray(o, d, mn, mx));
      o = '{0, 0, 0};                   d = '{0, 0, 0};
      ray_queue.push_back(pack_ray(o, d, mn, mx));
      o = '{32'h0005_0000, 0, 0};       d = '{32'h8000_0000, 0, 0};
      ray_queue.push_back(pack_ray(o, d, mn, mx));
      d = '{32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
      ray_queue.push_back(pack_ray(o, d, mn, mx));
      o = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      d = '{1, 1, 1};
      mn = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      mx = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      ray_queue.push_back(pack_ray(o, d, mn, mx));
      o = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      d = '{32'hFFFF_FFFF, 32'h8000_0000, 1};
      ray_queue.push_back(pack_ray(o, d, mx, mn));
      ray_queue.push_back('0);
      ray_queue.push_back('1);
      for (int i = 0; i < 8; i++) ray_queue.push_back(make_ray(1));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (ray_queue.size() == 0);
      pause_req = 1;
      wait (expected_hits.size() == 0);
      pause_req = 0;
      for (int i = 0; i < 60; i++) ray_queue.push_back(make_ray($urandom_range(0, 3) != 0));
      @(negedge clock) hold_off = 80;
      for (int i = 0; i < NumRandom - 60; i++)
         ray_queue.push_back(make_ray($urandom_range(0, 3) != 0));
      wait (ray_queue.size() == 0);
      stimulus_done = 1;
   end

   // item taken at the last rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
      end
   end

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (ray_queue.size() > 0 && !pause_req) begin
            req_tvalid <= 1'b1;
            req_tdata  <= ray_queue.pop_front();
            if (ray_queue.size() > 60 && $urandom_range(0, 15) == 0)
               send_gap <= $urandom_range(1, 19);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
         burst_on   <= 0;
      end else if (hold_off > 0) begin
         hold_off   <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap   <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (ray_queue.size() > 60 && $urandom_range(0, 15) == 0)
            recv_gap <= $urandom_range(1, 19);
      end
   end

   // monitor
   always @(posedge clock) begin
      slab_result_type got, want;
      if (reset) begin
         mismatches <= 0;
         idle_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_hits.push_back(predict_slab_hit(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[32:1]};
            if (expected_hits.size() == 0) begin
               if (mismatches < 10) $display("unexpected item: hit %0b entry_t %h",
                                             got.hit, got.entry_t);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_hits.pop_front();
               if (got !== want || rsp_tdata[39:33] !== '0) begin
                  if (mismatches < 10)
                     $display("mismatch: hit exp %0b got %0b, entry_t exp %h got %h",
                              want.hit, got.hit, want.entry_t, got.entry_t);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_count <= 0;
         else idle_count <= idle_count + 1;
         if (idle_count >= WatchdogLimit) begin
            $display("ray_box_slab_intersect verification failed");
            $finish;
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (expected_hits.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_hits.size() == 0)
         $display("ray_box_slab_intersect verification clean");
      else
         $display("ray_box_slab_intersect verification failed");
      $finish;
   end

endmodule
